// File: hdl/mpts_pkg.sv
// Shared types and constants for the multilevel priority task scheduler.
package mpts_pkg;

  // Request codes
  localparam logic [1:0] REQ_ADD      = 2'd0;
  localparam logic [1:0] REQ_REMOVE   = 2'd1;
  localparam logic [1:0] REQ_EXPIRE   = 2'd2;
  localparam logic [1:0] REQ_RESCHED  = 2'd3;

  // Result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_IDLE      = 2'd2;
  localparam logic [1:0] ST_DISABLED  = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] CFG_ENABLE   = 2'd0;
  localparam logic [1:0] CFG_SPECIAL  = 2'd1;
  localparam logic [1:0] CFG_NORMAL   = 2'd2;

  // Register reset values
  localparam logic [15:0] SPECIAL_SLICE_RST = 16'd100;
  localparam logic [15:0] NORMAL_SLICE_RST  = 16'd10;

  // Command broadcast to every queue cell
  typedef struct packed {
    logic settle;  // squeeze empty cells toward the tail
    logic ins;     // append an entry at the tail cell
    logic clr;     // drop every entry whose id matches
    logic take;    // drop the entry at the dispatched position
  } ctl_t;

endpackage

// File: hdl/mpts_cell.sv
// One cell of the ready-queue chain: holds one waiting task and one scan token stage.
module mpts_cell #(
  parameter int TASKS   = 64,
  parameter int ID_BITS = 16,
  parameter int LW      = 7,
  parameter int POS     = 0
) (
  input  logic                           clk,
  input  logic                           rst,
  input  mpts_pkg::ctl_t                 ctl,
  input  logic [ID_BITS-1:0]             key_id,
  input  logic [LW-1:0]                  ins_level,
  input  logic                           ins_special,
  input  logic [$clog2(TASKS)-1:0]       take_idx,
  input  logic                           unit_ready,
  input  logic                           up_valid,
  input  logic [ID_BITS-1:0]             up_id,
  input  logic [LW-1:0]                  up_level,
  input  logic                           up_special,
  input  logic                           down_valid,
  output logic                           valid,
  output logic [ID_BITS-1:0]             id,
  output logic [LW-1:0]                  level,
  output logic                           special,
  input  logic                           ci_found,
  input  logic                           ci_special,
  input  logic [LW-1:0]                  ci_level,
  input  logic [ID_BITS-1:0]             ci_id,
  input  logic [$clog2(TASKS)-1:0]       ci_idx,
  input  logic [$clog2(TASKS+1)-1:0]     ci_ncnt,
  input  logic [$clog2(TASKS+1)-1:0]     ci_scnt,
  output logic                           co_found,
  output logic                           co_special,
  output logic [LW-1:0]                  co_level,
  output logic [ID_BITS-1:0]             co_id,
  output logic [$clog2(TASKS)-1:0]       co_idx,
  output logic [$clog2(TASKS+1)-1:0]     co_ncnt,
  output logic [$clog2(TASKS+1)-1:0]     co_scnt
);
  import mpts_pkg::*;

  localparam int IDX_W = $clog2(TASKS);
  localparam int CW    = $clog2(TASKS + 1);
  localparam bit TOP   = (POS == TASKS - 1);

  logic elig;
  logic beat;

  // Entry valid bit: settle, insert, match drop, dispatch drop
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.settle) begin
      if (!valid) begin
        valid <= up_valid;
      end else if (!down_valid) begin
        valid <= 1'b0;
      end
    end else if (ctl.ins && TOP) begin
      valid <= 1'b1;
    end else if (ctl.clr && valid && (id == key_id)) begin
      valid <= 1'b0;
    end else if (ctl.take && (take_idx == IDX_W'(POS))) begin
      valid <= 1'b0;
    end
  end

  // Entry payload: pull from the upper neighbor into an empty cell, or load a new task
  always_ff @(posedge clk) begin
    if (ctl.settle && !valid) begin
      id      <= up_id;
      level   <= up_level;
      special <= up_special;
    end else if (ctl.ins && TOP) begin
      id      <= key_id;
      level   <= ins_level;
      special <= ins_special;
    end
  end

  // Special entries win when the unit is ready; else lowest level; ties keep the older
  assign elig = valid && (!special || unit_ready);
  assign beat = elig && (!ci_found || (special && !ci_special) ||
                         (!special && !ci_special && (level < ci_level)));

  // Advance the scan token one cell
  always_ff @(posedge clk) begin
    co_found   <= ci_found || elig;
    co_special <= beat ? special : ci_special;
    co_level   <= beat ? level : ci_level;
    co_id      <= beat ? id : ci_id;
    co_idx     <= beat ? IDX_W'(POS) : ci_idx;
    co_ncnt    <= ci_ncnt + CW'(valid && !special);
    co_scnt    <= ci_scnt + CW'(valid && special);
  end

endmodule

// File: hdl/multilevel_priority_task_scheduler_unit.sv
// Top level of the multilevel priority task scheduler: control, cell chain and result register.
//
// Requests arrive on the in_* channel (valid/stall) and each produces exactly one
// result on the out_* channel. A request adds a task, removes a task by id, expires
// the running task's slice, or asks for a reschedule. Waiting tasks sit in a chain
// of TASKS cells in arrival order; a special task is dispatched first when the
// special unit is ready, else the oldest task of the lowest priority level.
// A request runs through four steps: the chain is compacted, the request is applied,
// the scan token walks the chain, and the result is committed. in_stall is high
// while a request is in work. The result sits in an output register; if the receiver
// stalls, the next request is still taken and runs to its commit step, where it
// waits until the register frees up. Configuration writes on cfg_we are taken at
// any edge and must only happen while the block is idle. Reset empties every
// queue, stops the running task, disables the scheduler and restores the slice
// lengths to 100 (special) and 10 (ordinary).
module multilevel_priority_task_scheduler_unit #(
  parameter int LEVELS  = 128,
  parameter int TASKS   = 64,
  parameter int ID_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  req_type,
  input  logic [15:0] task_id,
  input  logic [7:0]  task_priority,
  input  logic        task_is_special,
  input  logic        special_unit_ready,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic        dispatch_valid,
  output logic [15:0] dispatch_id,
  output logic        dispatch_special,
  output logic [15:0] slice_len,
  output logic        running_valid,
  output logic [15:0] running_id,
  output logic [6:0]  normal_ready_count,
  output logic [6:0]  special_ready_count
);
  import mpts_pkg::*;

  localparam int LW    = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int IDX_W = $clog2(TASKS);
  localparam int CW    = $clog2(TASKS + 1);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SETTLE = 5'b00010,
    S_APPLY  = 5'b00100,
    S_SCAN   = 5'b01000,
    S_FINISH = 5'b10000
  } state_t;

  state_t state;
  logic [IDX_W-1:0] cyc;

  // Configuration registers
  logic        sched_enable;
  logic [15:0] special_slice;
  logic [15:0] normal_slice;

  // Latched request
  logic [1:0]         q_type;
  logic [ID_BITS-1:0] q_id;
  logic [LW-1:0]      q_level;
  logic               q_special;
  logic               q_ready;

  // Running task and queue counts
  logic               run_valid;
  logic [ID_BITS-1:0] run_id;
  logic [LW-1:0]      run_level;
  logic               run_special;
  logic [CW-1:0]      ncnt;
  logic [CW-1:0]      scnt;

  logic       resched;
  logic [1:0] a_status;

  // Chain wiring
  logic               c_valid   [TASKS];
  logic [ID_BITS-1:0] c_id      [TASKS];
  logic [LW-1:0]      c_level   [TASKS];
  logic               c_special [TASKS];
  logic               k_found   [TASKS];
  logic               k_special [TASKS];
  logic [LW-1:0]      k_level   [TASKS];
  logic [ID_BITS-1:0] k_id      [TASKS];
  logic [IDX_W-1:0]   k_idx     [TASKS];
  logic [CW-1:0]      k_ncnt    [TASKS];
  logic [CW-1:0]      k_scnt    [TASKS];

  ctl_t               ctl;
  logic [ID_BITS-1:0] key_id;
  logic [LW-1:0]      ins_level;
  logic               ins_special;

  logic [CW:0]  pool_used;
  logic         pool_full;
  logic         commit;
  logic         do_take;
  logic         fin_run_valid;
  logic [1:0]   fin_status;
  logic         f_found;
  logic         f_special;
  logic [ID_BITS-1:0] f_id;

  assign in_stall = (state != S_IDLE);

  assign pool_used = (CW+1)'(ncnt) + (CW+1)'(scnt) + (CW+1)'(run_valid);
  assign pool_full = pool_used >= (CW+1)'(TASKS);

  assign f_found   = k_found[TASKS-1];
  assign f_special = k_special[TASKS-1];
  assign f_id      = k_id[TASKS-1];

  assign commit  = (state == S_FINISH) && !(out_valid && out_stall);
  assign do_take = resched && sched_enable && f_found;

  // Cell commands for the current step
  always_comb begin
    ctl         = '0;
    key_id      = q_id;
    ins_level   = q_level;
    ins_special = q_special;
    case (state)
      S_SETTLE: ctl.settle = 1'b1;
      S_APPLY: begin
        case (q_type)
          REQ_ADD:    ctl.ins = !pool_full;
          REQ_REMOVE: ctl.clr = 1'b1;
          REQ_EXPIRE: begin
            ctl.ins     = run_valid;
            key_id      = run_id;
            ins_level   = run_level;
            ins_special = run_special;
          end
          default: ;
        endcase
      end
      S_FINISH: ctl.take = commit && do_take;
      default: ;
    endcase
  end

  // Result of the commit step
  always_comb begin
    fin_run_valid = run_valid;
    fin_status    = a_status;
    if (resched) begin
      if (!sched_enable) begin
        fin_status = ST_DISABLED;
      end else begin
        fin_run_valid = f_found;
        fin_status    = f_found ? ST_OK : ST_IDLE;
      end
    end
  end

  // Build the cell chain
  for (genvar i = 0; i < TASKS; i++) begin : g_cell
    logic               up_valid;
    logic [ID_BITS-1:0] up_id;
    logic [LW-1:0]      up_level;
    logic               up_special;
    logic               down_valid;
    logic               ci_found;
    logic               ci_special;
    logic [LW-1:0]      ci_level;
    logic [ID_BITS-1:0] ci_id;
    logic [IDX_W-1:0]   ci_idx;
    logic [CW-1:0]      ci_ncnt;
    logic [CW-1:0]      ci_scnt;

    if (i == TASKS - 1) begin : g_top
      assign up_valid   = 1'b0;
      assign up_id      = '0;
      assign up_level   = '0;
      assign up_special = 1'b0;
    end else begin : g_mid
      assign up_valid   = c_valid[i+1];
      assign up_id      = c_id[i+1];
      assign up_level   = c_level[i+1];
      assign up_special = c_special[i+1];
    end

    if (i == 0) begin : g_head
      assign down_valid = 1'b1;
      assign ci_found   = 1'b0;
      assign ci_special = 1'b0;
      assign ci_level   = '0;
      assign ci_id      = '0;
      assign ci_idx     = '0;
      assign ci_ncnt    = '0;
      assign ci_scnt    = '0;
    end else begin : g_body
      assign down_valid = c_valid[i-1];
      assign ci_found   = k_found[i-1];
      assign ci_special = k_special[i-1];
      assign ci_level   = k_level[i-1];
      assign ci_id      = k_id[i-1];
      assign ci_idx     = k_idx[i-1];
      assign ci_ncnt    = k_ncnt[i-1];
      assign ci_scnt    = k_scnt[i-1];
    end

    mpts_cell #(
      .TASKS   (TASKS),
      .ID_BITS (ID_BITS),
      .LW      (LW),
      .POS     (i)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctl         (ctl),
      .key_id      (key_id),
      .ins_level   (ins_level),
      .ins_special (ins_special),
      .take_idx    (k_idx[TASKS-1]),
      .unit_ready  (q_ready),
      .up_valid    (up_valid),
      .up_id       (up_id),
      .up_level    (up_level),
      .up_special  (up_special),
      .down_valid  (down_valid),
      .valid       (c_valid[i]),
      .id          (c_id[i]),
      .level       (c_level[i]),
      .special     (c_special[i]),
      .ci_found    (ci_found),
      .ci_special  (ci_special),
      .ci_level    (ci_level),
      .ci_id       (ci_id),
      .ci_idx      (ci_idx),
      .ci_ncnt     (ci_ncnt),
      .ci_scnt     (ci_scnt),
      .co_found    (k_found[i]),
      .co_special  (k_special[i]),
      .co_level    (k_level[i]),
      .co_id       (k_id[i]),
      .co_idx      (k_idx[i]),
      .co_ncnt     (k_ncnt[i]),
      .co_scnt     (k_scnt[i])
    );
  end

  // Control: sequencer, configuration, running task, counts, result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      cyc           <= '0;
      sched_enable  <= 1'b0;
      special_slice <= SPECIAL_SLICE_RST;
      normal_slice  <= NORMAL_SLICE_RST;
      run_valid     <= 1'b0;
      ncnt          <= '0;
      scnt          <= '0;
      out_valid     <= 1'b0;
    end else begin
      // Write configuration
      if (cfg_we) begin
        case (cfg_index)
          CFG_ENABLE:  sched_enable  <= cfg_data[0];
          CFG_SPECIAL: special_slice <= cfg_data;
          CFG_NORMAL:  normal_slice  <= cfg_data;
          default: ;
        endcase
      end

      // Drop the result once taken, unless a new one is loaded in the same cycle
      if (out_valid && !out_stall && !commit) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_SETTLE;
            cyc   <= '0;
          end
        end
        S_SETTLE: begin
          cyc <= cyc + IDX_W'(1);
          if (cyc == IDX_W'(TASKS - 1)) begin
            state <= S_APPLY;
          end
        end
        S_APPLY: begin
          state <= S_SCAN;
          cyc   <= '0;
          case (q_type)
            REQ_REMOVE: begin
              if (run_valid && (run_id == q_id)) begin
                run_valid <= 1'b0;
              end
            end
            REQ_EXPIRE: run_valid <= 1'b0;
            default: ;
          endcase
        end
        S_SCAN: begin
          cyc <= cyc + IDX_W'(1);
          if (cyc == IDX_W'(TASKS - 1)) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (commit) begin
            state     <= S_IDLE;
            out_valid <= 1'b1;
            run_valid <= fin_run_valid;
            ncnt      <= k_ncnt[TASKS-1] - CW'(do_take && !f_special);
            scnt      <= k_scnt[TASKS-1] - CW'(do_take && f_special);
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Latch the request and work out the apply-step status
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      q_type    <= req_type;
      q_id      <= ID_BITS'(task_id);
      q_level   <= ({1'b0, task_priority} >= 9'(LEVELS)) ? LW'(LEVELS - 1)
                                                          : LW'(task_priority);
      q_special <= task_is_special;
      q_ready   <= special_unit_ready;
    end
    if (state == S_APPLY) begin
      resched  <= 1'b0;
      a_status <= ST_OK;
      case (q_type)
        REQ_ADD: begin
          if (pool_full) begin
            a_status <= ST_FULL;
          end
        end
        REQ_REMOVE: resched <= run_valid && (run_id == q_id);
        REQ_EXPIRE: begin
          if (run_valid) begin
            resched <= 1'b1;
          end else begin
            a_status <= ST_IDLE;
          end
        end
        default: resched <= 1'b1;
      endcase
    end
  end

  // Load the running task and the result payload at commit
  always_ff @(posedge clk) begin
    if (commit) begin
      if (do_take) begin
        run_id      <= f_id;
        run_level   <= k_level[TASKS-1];
        run_special <= f_special;
      end
      status              <= fin_status;
      dispatch_valid      <= do_take;
      dispatch_id         <= do_take ? 16'(f_id) : 16'd0;
      dispatch_special    <= do_take && f_special;
      slice_len           <= do_take ? (f_special ? special_slice : normal_slice) : 16'd0;
      running_valid       <= fin_run_valid;
      running_id          <= !fin_run_valid ? 16'd0 : (do_take ? 16'(f_id) : 16'(run_id));
      normal_ready_count  <= 7'(k_ncnt[TASKS-1] - CW'(do_take && !f_special));
      special_ready_count <= 7'(k_scnt[TASKS-1] - CW'(do_take && f_special));
    end
  end

  // The pool never holds more tasks than it has slots
  assert property (@(posedge clk) disable iff (rst)
    pool_used <= (CW+1)'(TASKS))
    else $error("task pool overfilled");

  // A dispatched task is reported as running
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && dispatch_valid) |-> running_valid)
    else $error("dispatch without running task");

  // A dropped add never dispatches
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status == ST_FULL)) |-> !dispatch_valid)
    else $error("dispatch on dropped add");

  // An accepted request starts with the compaction sweep
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == S_SETTLE))
    else $error("request not started");

endmodule

// File: tb/tb_multilevel_priority_task_scheduler_unit.sv
// Self-checking testbench for the multilevel priority task scheduler: directed table plus random requests.
`timescale 1ns / 100ps

module tb_multilevel_priority_task_scheduler_unit;
  import mpts_pkg::*;

  localparam int NLEV = 128;
  localparam int NSLOT = 64;
  localparam int SPQ = NLEV;            // queue index used for the special queue
  localparam int WATCH_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 300;

  typedef struct packed {
    logic [1:0]  status;
    logic        dvalid;
    logic [15:0] did;
    logic        dspecial;
    logic [15:0] slen;
    logic        rvalid;
    logic [15:0] rid;
    logic [6:0]  ncount;
    logic [6:0]  scount;
  } sched_result_t;

  typedef struct {
    bit          is_cfg;
    logic [1:0]  req;      // register index for a config row
    logic [15:0] id;       // write data for a config row
    logic [7:0]  pri;
    logic        spec;
    logic        ready;
    bit          typed;
    logic [1:0]  st;
  } dir_row_t;

  logic        clk, rst;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;
  logic        in_valid, in_stall;
  logic [1:0]  req_type;
  logic [15:0] task_id;
  logic [7:0]  task_priority;
  logic        task_is_special, special_unit_ready;
  logic        out_valid, out_stall;
  logic [1:0]  status;
  logic        dispatch_valid;
  logic [15:0] dispatch_id;
  logic        dispatch_special;
  logic [15:0] slice_len;
  logic        running_valid;
  logic [15:0] running_id;
  logic [6:0]  normal_ready_count, special_ready_count;

  multilevel_priority_task_scheduler_unit dut (.*);

  // Shadow scheduler state
  logic [15:0] sh_id[NSLOT];
  logic [6:0]  sh_pri[NSLOT];
  bit          sh_spec[NSLOT];
  logic [5:0]  sh_next[NSLOT];
  bit          sh_free[NSLOT];
  logic [5:0]  q_head[NLEV+1];
  logic [5:0]  q_tail[NLEV+1];
  bit          q_ne[NLEV+1];
  int          norm_cnt, spec_cnt;
  logic [5:0]  run_slot;
  bit          run_flag;
  logic        en_reg;
  logic [15:0] spec_slice, norm_slice;

  sched_result_t pending_q[$];
  int  errors;
  int  idle_cycles;
  bit  quiet;
  int  ostall_cnt;
  dir_row_t dir_tab[$];

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  function automatic int queue_of(logic [5:0] s);
    return sh_spec[s] ? SPQ : int'(sh_pri[s]);
  endfunction

  function automatic void q_push(logic [5:0] s);
    int q;
    q = queue_of(s);
    if (q_ne[q]) sh_next[q_tail[q]] = s;
    else q_head[q] = s;
    q_tail[q] = s;
    q_ne[q] = 1;
    if (q == SPQ) spec_cnt++;
    else norm_cnt++;
  endfunction

  function automatic logic [5:0] q_pop(int q);
    logic [5:0] s;
    s = q_head[q];
    if (s == q_tail[q]) q_ne[q] = 0;
    else q_head[q] = sh_next[s];
    return s;
  endfunction

  // Unlink every entry of queue q whose id matches; return how many went
  function automatic int q_purge(int q, logic [15:0] id);
    int n;
    logic [5:0] cur, prv, nxt;
    bit has_prv, last;
    n = 0;
    has_prv = 0;
    prv = 0;
    if (!q_ne[q]) return 0;
    cur = q_head[q];
    for (int g = 0; g < NSLOT; g++) begin
      last = (cur == q_tail[q]);
      nxt = sh_next[cur];
      if (sh_id[cur] == id) begin
        sh_free[cur] = 1;
        n++;
        if (!has_prv) begin
          if (last) q_ne[q] = 0;
          else q_head[q] = nxt;
        end else begin
          sh_next[prv] = nxt;
          if (last) q_tail[q] = prv;
        end
      end else begin
        prv = cur;
        has_prv = 1;
      end
      if (last) break;
      cur = nxt;
    end
    return n;
  endfunction

  function automatic logic [1:0] redispatch(logic ready, output bit disp);
    disp = 0;
    if (!en_reg) return ST_DISABLED;
    if (run_flag) begin
      sh_free[run_slot] = 1;
      run_flag = 0;
    end
    if (ready && q_ne[SPQ]) begin
      run_slot = q_pop(SPQ);
      spec_cnt--;
      run_flag = 1;
      disp = 1;
      return ST_OK;
    end
    for (int lv = 0; lv < NLEV; lv++) begin
      if (q_ne[lv]) begin
        run_slot = q_pop(lv);
        norm_cnt--;
        run_flag = 1;
        disp = 1;
        return ST_OK;
      end
    end
    return ST_IDLE;
  endfunction

  // Apply one request to the shadow state and return the result it should give
  function automatic sched_result_t schedule_step(logic [1:0] req, logic [15:0] id,
                                                  logic [7:0] pri, logic spec, logic ready);
    sched_result_t r;
    bit disp;
    int s;
    r = '0;
    disp = 0;
    case (req)
      REQ_ADD: begin
        s = -1;
        for (int i = 0; i < NSLOT; i++)
          if (sh_free[i]) begin
            s = i;
            break;
          end
        if (s < 0) r.status = ST_FULL;
        else begin
          sh_free[s] = 0;
          sh_id[s] = id;
          sh_pri[s] = (pri < NLEV) ? pri[6:0] : 7'(NLEV - 1);
          sh_spec[s] = spec;
          q_push(6'(s));
        end
      end
      REQ_REMOVE: begin
        for (int lv = 0; lv < NLEV; lv++) norm_cnt -= q_purge(lv, id);
        spec_cnt -= q_purge(SPQ, id);
        if (run_flag && sh_id[run_slot] == id) begin
          sh_free[run_slot] = 1;
          run_flag = 0;
          r.status = redispatch(ready, disp);
        end
      end
      REQ_EXPIRE: begin
        if (!run_flag) r.status = ST_IDLE;
        else begin
          q_push(run_slot);
          run_flag = 0;
          r.status = redispatch(ready, disp);
        end
      end
      default: r.status = redispatch(ready, disp);
    endcase
    r.dvalid = disp;
    if (disp) begin
      r.did = sh_id[run_slot];
      r.dspecial = sh_spec[run_slot];
      r.slen = sh_spec[run_slot] ? spec_slice : norm_slice;
    end
    r.rvalid = run_flag;
    r.rid = run_flag ? sh_id[run_slot] : 16'd0;
    r.ncount = 7'(norm_cnt);
    r.scount = 7'(spec_cnt);
    return r;
  endfunction

  task automatic add_row(bit c, logic [1:0] rq, logic [15:0] id, logic [7:0] pri,
                         logic sp, logic rd, bit ty, logic [1:0] st);
    dir_row_t w;
    w.is_cfg = c; w.req = rq; w.id = id; w.pri = pri;
    w.spec = sp; w.ready = rd; w.typed = ty; w.st = st;
    dir_tab.push_back(w);
  endtask

  // Wait for all results, then write one register; called at a falling edge
  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    in_valid = 0;
    while (pending_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_we = 1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 0;
    case (idx)
      CFG_ENABLE:  en_reg = val[0];
      CFG_SPECIAL: spec_slice = val;
      default:     norm_slice = val;
    endcase
  endtask

  // Present one request and hold it until accepted; called at a falling edge
  task automatic send_req(logic [1:0] rq, logic [15:0] id, logic [7:0] pri, logic sp,
                          logic rd, bit ty, logic [1:0] st);
    sched_result_t e;
    int n;
    if (!quiet && $urandom_range(3) == 0) begin
      n = $urandom_range(1, 13);
      in_valid = 0;
      repeat (n) @(negedge clk);
    end
    req_type = rq; task_id = id; task_priority = pri;
    task_is_special = sp; special_unit_ready = rd;
    in_valid = 1;
    do @(posedge clk); while (in_stall);
    e = schedule_step(rq, id, pri, sp, rd);
    if (ty) e.status = st;
    pending_q.push_back(e);
    @(negedge clk);
  endtask

  task automatic chk_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      errors++;
    end
  endtask

  // Check each delivered result against the oldest prediction
  always @(posedge clk) begin
    sched_result_t e;
    if (!rst && out_valid && !out_stall) begin
      if (pending_q.size() == 0) begin
        $error("unexpected result: status %0d", status);
        errors++;
      end else begin
        e = pending_q.pop_front();
        chk_field("status", 16'(e.status), 16'(status));
        chk_field("dispatch_valid", 16'(e.dvalid), 16'(dispatch_valid));
        chk_field("dispatch_id", e.did, dispatch_id);
        chk_field("dispatch_special", 16'(e.dspecial), 16'(dispatch_special));
        chk_field("slice_len", e.slen, slice_len);
        chk_field("running_valid", 16'(e.rvalid), 16'(running_valid));
        chk_field("running_id", e.rid, running_id);
        chk_field("normal_ready_count", 16'(e.ncount), 16'(normal_ready_count));
        chk_field("special_ready_count", 16'(e.scount), 16'(special_ready_count));
      end
    end
  end

  // Receiver stall bursts
  always @(negedge clk) begin
    if (quiet || rst) out_stall = 0;
    else begin
      if (ostall_cnt == 0) begin
        if ($urandom_range(2) == 0) begin
          out_stall = 1;
          ostall_cnt = $urandom_range(1, 13);
        end else begin
          out_stall = 0;
          ostall_cnt = $urandom_range(1, 20);
        end
      end
      ostall_cnt--;
    end
  end

  // Watchdog on cycles with no handshake on either channel
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCH_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    int p_add, r;
    logic [1:0] rq;
    logic [15:0] id;
    logic [7:0] pri;
    errors = 0; idle_cycles = 0; quiet = 0; ostall_cnt = 0;
    rst = 1; cfg_we = 0; cfg_index = CFG_ENABLE; cfg_data = '0;
    in_valid = 0; out_stall = 0;
    req_type = REQ_ADD; task_id = '0; task_priority = '0;
    task_is_special = 0; special_unit_ready = 0;
    for (int i = 0; i < NSLOT; i++) begin
      sh_free[i] = 1; sh_id[i] = 0; sh_pri[i] = 0; sh_spec[i] = 0; sh_next[i] = 0;
    end
    for (int q = 0; q <= NLEV; q++) begin
      q_head[q] = 0; q_tail[q] = 0; q_ne[q] = 0;
    end
    norm_cnt = 0; spec_cnt = 0; run_slot = 0; run_flag = 0;
    en_reg = 0; spec_slice = SPECIAL_SLICE_RST; norm_slice = NORMAL_SLICE_RST;

    // Directed table: disabled behavior, extremes, clamping, removal of running task
    add_row(0, REQ_RESCHED, 16'h0000, 8'd0,   1, 1, 1, ST_DISABLED);
    add_row(0, REQ_EXPIRE,  16'h0000, 8'd0,   0, 0, 1, ST_IDLE);
    add_row(0, REQ_ADD,     16'hFFFF, 8'd255, 0, 0, 1, ST_OK);
    add_row(0, REQ_ADD,     16'h0000, 8'd0,   1, 1, 1, ST_OK);
    add_row(0, REQ_ADD,     16'h0007, 8'd127, 0, 0, 1, ST_OK);
    add_row(0, REQ_ADD,     16'h0008, 8'd128, 0, 1, 1, ST_OK);
    add_row(0, REQ_REMOVE,  16'h0007, 8'd0,   0, 0, 1, ST_OK);
    add_row(1, CFG_ENABLE,  16'd1,    8'd0,   0, 0, 0, ST_OK);
    add_row(0, REQ_RESCHED, 16'h0000, 8'd0,   0, 1, 0, ST_OK);
    add_row(0, REQ_EXPIRE,  16'h0000, 8'd0,   0, 0, 0, ST_OK);
    add_row(0, REQ_RESCHED, 16'h0000, 8'd0,   0, 1, 0, ST_OK);
    add_row(0, REQ_REMOVE,  16'hFFFF, 8'd0,   0, 1, 0, ST_OK);
    add_row(0, REQ_RESCHED, 16'h0000, 8'd0,   0, 0, 0, ST_OK);
    add_row(0, REQ_RESCHED, 16'h0000, 8'd0,   0, 0, 0, ST_OK);
    add_row(1, CFG_SPECIAL, 16'hFFFF, 8'd0,   0, 0, 0, ST_OK);
    add_row(1, CFG_NORMAL,  16'd1,    8'd0,   0, 0, 0, ST_OK);
    add_row(0, REQ_ADD,     16'h0003, 8'd1,   1, 0, 0, ST_OK);
    add_row(0, REQ_ADD,     16'h0003, 8'd1,   0, 0, 0, ST_OK);
    add_row(0, REQ_ADD,     16'h0003, 8'd2,   0, 0, 0, ST_OK);
    add_row(0, REQ_RESCHED, 16'h0000, 8'd0,   0, 1, 0, ST_OK);
    add_row(0, REQ_REMOVE,  16'h0003, 8'd0,   0, 1, 0, ST_OK);
    add_row(0, REQ_RESCHED, 16'h0000, 8'd0,   0, 1, 0, ST_OK);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 0;

    foreach (dir_tab[i]) begin
      if (dir_tab[i].is_cfg) write_reg(dir_tab[i].req, dir_tab[i].id);
      else send_req(dir_tab[i].req, dir_tab[i].id, dir_tab[i].pri, dir_tab[i].spec,
                    dir_tab[i].ready, dir_tab[i].typed, dir_tab[i].st);
    end

    // Random phases, each under its own register setting
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin write_reg(CFG_ENABLE, 16'd1); write_reg(CFG_SPECIAL, 16'd1);
                 write_reg(CFG_NORMAL, 16'hFFFF); p_add = 70; end
        1: begin write_reg(CFG_SPECIAL, 16'hFFFF); write_reg(CFG_NORMAL, 16'd1); p_add = 45; end
        2: begin write_reg(CFG_ENABLE, 16'd0);
                 write_reg(CFG_SPECIAL, 16'($urandom_range(1, 65535)));
                 p_add = 40; end
        3: begin write_reg(CFG_ENABLE, 16'd1);
                 write_reg(CFG_NORMAL, 16'($urandom_range(1, 65535)));
                 p_add = 85; end
        4: begin write_reg(CFG_SPECIAL, SPECIAL_SLICE_RST); write_reg(CFG_NORMAL,
                 NORMAL_SLICE_RST); p_add = 35; end
        default: begin quiet = 1; write_reg(CFG_SPECIAL, 16'($urandom_range(1, 65535)));
                 p_add = 50; end
      endcase
      repeat (255) begin
        r = $urandom_range(99);
        if (r < p_add) rq = REQ_ADD;
        else if (r < p_add + (100 - p_add) / 4) rq = REQ_REMOVE;
        else if (r < p_add + (100 - p_add) / 2) rq = REQ_EXPIRE;
        else rq = REQ_RESCHED;
        // Mostly a small id set so removals hit queued and running tasks
        id = ($urandom_range(3) != 0) ? 16'($urandom_range(0, 15)) : 16'($urandom());
        r = $urandom_range(3);
        pri = (r < 2) ? 8'($urandom_range(0, 3)) :
              (r == 2) ? 8'($urandom()) : 8'($urandom_range(126, 130));
        send_req(rq, id, pri, $urandom_range(3) == 0, 1'($urandom_range(1)), 0, ST_OK);
      end
    end

    in_valid = 0;
    while (pending_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

// File: files.f
hdl/mpts_pkg.sv
hdl/mpts_cell.sv
hdl/multilevel_priority_task_scheduler_unit.sv
tb/tb_multilevel_priority_task_scheduler_unit.sv
